// ===== rtl/core/tilt_angle_rate_estimator_macros.svh =====
// Assertion macros shared by the tilt angle and rate estimator RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef TILT_ANGLE_RATE_ESTIMATOR_MACROS_SVH
`define TILT_ANGLE_RATE_ESTIMATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TARE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TARE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tare_pkg.sv =====
// Types and constants of the tilt angle and rate estimator.
// Used by tare_div and tilt_angle_rate_estimator; depends on nothing.
`default_nettype none

package tare_pkg;

  // Internal widths, set by the ranges of the angle and rate fields.
  localparam int ANG_W     = 25;  // angle accumulator, 2^-8 of 1/128 deg
  localparam int ADIFF_W   = 26;
  localparam int RACC_W    = 40;  // rate accumulator, 2^-16 of 1/128 deg/s
  localparam int RDIFF_W   = 41;
  localparam int RLO_W     = 24;  // low part of the split rate difference
  localparam int RATE_W    = 24;
  localparam int ANGLE_W   = 16;
  localparam int ALPHA_W   = 17;
  localparam int MUL_A_W   = 26;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = 44;
  localparam int NUM_W     = 40;  // divider dividend and quotient
  localparam int DEN_W     = 18;  // divider divisor, four times elapsed_us
  localparam int RSUM_W    = 60;
  localparam int SEQ_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [MUL_B_W-1:0] US_SCALE    = 18'd15625;
  localparam logic [NUM_W-1:0]   RATE_POS_LIM = 40'd8388607;
  localparam logic [NUM_W-1:0]   RATE_NEG_LIM = 40'd8388608;
  localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ROLL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ALPHA = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ANG_MUL,
    ST_ANG_UPD,
    ST_DELTA,
    ST_NUM_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RDIFF,
    ST_RATE_LO,
    ST_RATE_HI,
    ST_RATE_UPD,
    ST_OUT
  } tare_state_t;

  typedef enum logic [1:0] {
    MUL_ANGLE,
    MUL_NUM,
    MUL_RLO,
    MUL_RHI
  } mul_sel_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_load;
    mul_sel_t mul_sel;
    div_ctl_t div;
  } seq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tilt_angle_rate_estimator.sv =====
// Tilt angle and rate estimator: one-axis angle low-pass with a
// differentiated, low-passed rate. Depends on tare_pkg, tare_div and
// tilt_angle_rate_estimator_macros.svh.
//
// Usage:
//  - in_* carries one word per IMU update: pitch, roll and elapsed time.
//    A word with an elapsed time of 0 or 1 us is taken and dropped.
//  - out_* returns one word per kept update: filtered angle, filtered rate
//    and sequence number; out_tuser flags a saturated raw rate.
//  - cfg_* writes the registers and is always ready; write only while idle.
//  - Order: the first kept word after reset seeds the filters and goes
//    from its prep step straight to the output step. Every later word
//    also runs the bit-serial divider (load, 40 quotient steps and
//    finish); one shared 26x18 multiplier serves the rest.
//  - in_tready is high only while no word is in work, so a new word is
//    taken only once the last one is through; a dropped word is never in work.
//  - A result waits in the output register while out_tready is low; the
//    next input word is still taken and runs up to its output step.
//  - Reset restores the register defaults, clears the filters and the
//    sequence count and marks the block as not yet seeded.
`default_nettype none

module tilt_angle_rate_estimator (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: pitch_angle [15:0], roll_angle [31:16], elapsed_us [47:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata: filtered_angle [15:0], filtered_rate [39:16], sequence_res [71:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // out_tuser: rate_clipped [0]
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tare_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tare_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tare_pkg::*;

  // Configuration registers.
  logic                      use_roll_r;
  logic                      invert_r;
  logic signed [15:0]        offset_r;
  logic [ALPHA_W-1:0]        ang_alpha_r;
  logic [ALPHA_W-1:0]        rate_alpha_r;

  tare_state_t               state_r, state_nxt;
  seq_ctl_t                  ctl;

  logic signed [ANG_W-1:0]   target_r;
  logic [15:0]               dt_r;
  logic signed [ANG_W-1:0]   acc_r;
  logic signed [ANG_W-1:0]   prev_r;
  logic signed [RACC_W-1:0]  rate_acc_r;
  logic                      seeded_r;
  logic [SEQ_W-1:0]          count_r;
  logic signed [ADIFF_W-1:0] adiff_r;
  logic signed [ADIFF_W-1:0] d_r;
  logic signed [RDIFF_W-1:0] rdiff_r;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_P_W-1:0] prod_hi_r;
  logic                      num_neg_r;
  logic signed [RATE_W-1:0]  q_r;
  logic                      clipped_r;

  logic [ANGLE_W-1:0]        out_angle_r;
  logic [RATE_W-1:0]         out_rate_r;
  logic [SEQ_W-1:0]          out_seq_r;
  logic                      out_clip_r;
  logic                      out_valid_r;

  logic signed [15:0]        in_pitch;
  logic signed [15:0]        in_roll;
  logic [15:0]               in_elapsed;
  logic                      in_accept;
  logic                      dt_ok;
  logic signed [17:0]        raw_sel;
  logic signed [17:0]        raw_sum;

  logic [ALPHA_W-1:0]        ang_a;
  logic [ALPHA_W-1:0]        rate_a;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic [ANG_W+2:0]          ang_sum;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          num_mag;
  div_stat_t                 div_stat;
  logic [NUM_W-1:0]          q_mag;
  logic                      q_clip;
  logic signed [RATE_W-1:0]  q_sat;
  logic signed [RDIFF_W-1:0] rate_tgt;
  logic signed [RSUM_W-1:0]  rsum;

  logic signed [ANG_W:0]     ang_round;
  logic signed [ANG_W-8:0]   ang_scaled;
  logic signed [RACC_W:0]    rate_round;
  logic signed [RACC_W-16:0] rate_scaled;
  logic [ANGLE_W-1:0]        angle_out;
  logic [RATE_W-1:0]         rate_out;

  assign in_pitch   = in_tdata[15:0];
  assign in_roll    = in_tdata[31:16];
  assign in_elapsed = in_tdata[47:32];
  assign in_accept  = in_tvalid && ctl.in_ready;
  assign dt_ok      = |in_elapsed[15:1];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_roll_r   <= 1'b1;
      invert_r     <= 1'b0;
      offset_r     <= '0;
      ang_alpha_r  <= 17'd16384;
      rate_alpha_r <= 17'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USE_ROLL:   use_roll_r   <= cfg_data[0];
        CFG_INVERT:     invert_r     <= cfg_data[0];
        CFG_OFFSET:     offset_r     <= cfg_data[15:0];
        CFG_ANG_ALPHA:  ang_alpha_r  <= cfg_data;
        CFG_RATE_ALPHA: rate_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_accept && dt_ok) state_nxt = ST_PREP;
      ST_PREP:      state_nxt = seeded_r ? ST_ANG_MUL : ST_OUT;
      ST_ANG_MUL:   state_nxt = ST_ANG_UPD;
      ST_ANG_UPD:   state_nxt = ST_DELTA;
      ST_DELTA:     state_nxt = ST_NUM_MUL;
      ST_NUM_MUL:   state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_stat.done) state_nxt = ST_RDIFF;
      ST_RDIFF:     state_nxt = ST_RATE_LO;
      ST_RATE_LO:   state_nxt = ST_RATE_HI;
      ST_RATE_HI:   state_nxt = ST_RATE_UPD;
      ST_RATE_UPD:  state_nxt = ST_OUT;
      ST_OUT:       if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.mul_sel   = MUL_ANGLE;
    ctl.in_ready  = (state_r == ST_IDLE);
    ctl.out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);
    ctl.div.start = (state_r == ST_DIV_START);
    unique case (state_r)
      ST_NUM_MUL: ctl.mul_sel = MUL_NUM;
      ST_RATE_LO: ctl.mul_sel = MUL_RLO;
      ST_RATE_HI: ctl.mul_sel = MUL_RHI;
      default:    ctl.mul_sel = MUL_ANGLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------ shared multiplier
  assign ang_a  = (ang_alpha_r > ALPHA_ONE) ? ALPHA_ONE : ang_alpha_r;
  assign rate_a = (rate_alpha_r > ALPHA_ONE) ? ALPHA_ONE : rate_alpha_r;

  always_comb begin
    unique case (ctl.mul_sel)
      MUL_ANGLE: begin
        mul_a = adiff_r;
        mul_b = $signed({1'b0, ang_a});
      end
      MUL_NUM: begin
        mul_a = d_r;
        mul_b = $signed(US_SCALE);
      end
      MUL_RLO: begin
        mul_a = $signed(MUL_A_W'(rdiff_r[RLO_W-1:0]));
        mul_b = $signed({1'b0, rate_a});
      end
      MUL_RHI: begin
        mul_a = MUL_A_W'($signed(rdiff_r[RDIFF_W-1:RLO_W]));
        mul_b = $signed({1'b0, rate_a});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // --------------------------------------------------------------- divider
  // The rate is the angle change times 15625 over four times elapsed_us,
  // truncated toward zero, so the divider works on the magnitude.
  assign num     = prod_r[NUM_W-1:0];
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  tare_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl.div),
    .dividend (num_mag),
    .divisor  ({dt_r, 2'b00}),
    .stat     (div_stat),
    .quotient (q_mag)
  );

  always_comb begin
    if (num_neg_r) begin
      q_clip = q_mag > RATE_NEG_LIM;
      q_sat  = q_clip ? RATE_MIN : -$signed(q_mag[RATE_W-1:0]);
    end else begin
      q_clip = q_mag > RATE_POS_LIM;
      q_sat  = q_clip ? RATE_MAX : $signed(q_mag[RATE_W-1:0]);
    end
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    raw_sel = use_roll_r ? 18'(in_roll) : 18'(in_pitch);
    if (invert_r) begin
      raw_sel = -raw_sel;
    end
    raw_sum = raw_sel + 18'(offset_r);
  end

  assign ang_sum  = (ANG_W+3)'(acc_r) + prod_r[MUL_P_W-1:16];
  assign rate_tgt = RDIFF_W'($signed({q_r, 16'h0000}));
  assign rsum     = (RSUM_W'(prod_hi_r) <<< RLO_W) + RSUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      prev_r     <= '0;
      rate_acc_r <= '0;
      seeded_r   <= 1'b0;
      clipped_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_PREP: begin
          if (!seeded_r) begin
            acc_r      <= target_r;
            prev_r     <= target_r;
            rate_acc_r <= '0;
            seeded_r   <= 1'b1;
            clipped_r  <= 1'b0;
          end
        end
        ST_ANG_UPD:  acc_r <= ang_sum[ANG_W-1:0];
        ST_DELTA:    prev_r <= acc_r;
        ST_DIV_WAIT: if (div_stat.done) clipped_r <= q_clip;
        ST_RATE_UPD: rate_acc_r <= rate_acc_r + rsum[16 +: RACC_W];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      target_r <= $signed({raw_sum[ANG_W-9:0], 8'h00});
      dt_r     <= in_elapsed;
    end
    if (state_r == ST_PREP) begin
      adiff_r <= ADIFF_W'(target_r) - ADIFF_W'(acc_r);
    end
    if (state_r == ST_DELTA) begin
      d_r <= ADIFF_W'(acc_r) - ADIFF_W'(prev_r);
    end
    if (state_r == ST_ANG_MUL || state_r == ST_NUM_MUL || state_r == ST_RATE_LO) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_RATE_HI) begin
      prod_hi_r <= mul_p;
    end
    if (state_r == ST_DIV_START) begin
      num_neg_r <= num[NUM_W-1];
    end
    if (state_r == ST_DIV_WAIT && div_stat.done) begin
      q_r <= q_sat;
    end
    if (state_r == ST_RDIFF) begin
      rdiff_r <= rate_tgt - RDIFF_W'(rate_acc_r);
    end
  end

  // ---------------------------------------------------------------- output
  // Round to nearest with ties upward, then saturate to the field range.
  always_comb begin
    ang_round   = (ANG_W+1)'(acc_r) + (ANG_W+1)'(128);
    ang_scaled  = ang_round[ANG_W:8];
    rate_round  = (RACC_W+1)'(rate_acc_r) + (RACC_W+1)'(32768);
    rate_scaled = rate_round[RACC_W:16];
    if (ang_scaled > (ANG_W-7)'(32767)) begin
      angle_out = 16'h7FFF;
    end else if (ang_scaled < -(ANG_W-7)'(32768)) begin
      angle_out = 16'h8000;
    end else begin
      angle_out = ang_scaled[ANGLE_W-1:0];
    end
    if (rate_scaled > (RACC_W-15)'(RATE_MAX)) begin
      rate_out = RATE_MAX;
    end else if (rate_scaled < (RACC_W-15)'(RATE_MIN)) begin
      rate_out = RATE_MIN;
    end else begin
      rate_out = rate_scaled[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
        count_r     <= count_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_angle_r <= angle_out;
      out_rate_r  <= rate_out;
      out_seq_r   <= count_r + 1'b1;
      out_clip_r  <= clipped_r;
    end
  end

  assign in_tready  = ctl.in_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_seq_r, out_rate_r, out_angle_r};
  assign out_tuser  = out_clip_r;

  // ------------------------------------------------------------ assertions
  `include "tilt_angle_rate_estimator_macros.svh"

  `TARE_ASSERT_NEXT(a_short_dt_dropped, clk, rst_n, in_accept && !dt_ok, state_r == ST_IDLE, "short elapsed time word was not dropped")
  `TARE_ASSERT_SAME(a_div_done_in_wait, clk, rst_n, div_stat.done, state_r == ST_DIV_WAIT, "divider finished outside its wait step")
  `TARE_ASSERT_NEXT(a_count_steps, clk, rst_n, ctl.out_load, count_r == $past(count_r) + 1'b1 && out_valid_r, "result load did not advance the sequence count")
  `TARE_ASSERT_SAME(a_filter_seeded, clk, rst_n, state_r == ST_ANG_MUL, seeded_r, "filter update ran before seeding")

endmodule

`default_nettype wire

// ===== rtl/core/tare_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tare_pkg for widths and the control and status structs.
`default_nettype none

module tare_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tare_pkg::div_ctl_t          ctl,
  input  logic [tare_pkg::NUM_W-1:0]  dividend,
  input  logic [tare_pkg::DEN_W-1:0]  divisor,
  output tare_pkg::div_stat_t         stat,
  output logic [tare_pkg::NUM_W-1:0]  quotient
);
  import tare_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ===== dv/tilt_angle_rate_estimator_test.sv =====
// Self-checking testbench for tilt_angle_rate_estimator: drives IMU words, predicts
// filtered angle, rate, sequence number and clip flag, and checks every result word.
// Depends on tare_pkg and the estimator RTL.
`timescale 1ns / 100ps

module tilt_angle_rate_estimator_test;
  import tare_pkg::*;

  localparam int ANGLE_SPAN   = 23040;
  localparam longint ANGLE_TOP    = 32767;
  localparam longint ANGLE_BOTTOM = -32768;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_UPDATES = 154;
  localparam int RANDOM_PHASES = 8;

  typedef struct {
    logic [15:0] angle;
    logic [23:0] rate;
    logic [31:0] seq;
    logic        clipped;
  } tilt_estimate_t;

  class tilt_scoreboard;
    bit          use_roll;
    bit          invert;
    int          mount_offset;
    int unsigned angle_alpha;
    int unsigned rate_alpha;
    longint      angle_acc;
    longint      prev_angle;
    longint      rate_acc;
    bit          seeded;
    logic [31:0] updates;
    tilt_estimate_t pending[$];
    int mismatches;
    int checked;
    int dropped;
    int clipped_seen;
    int reg_writes;

    function new();
      use_roll     = 1'b1;
      invert       = 1'b0;
      mount_offset = 0;
      angle_alpha  = 16384;
      rate_alpha   = 16384;
      angle_acc    = 0;
      prev_angle   = 0;
      rate_acc     = 0;
      seeded       = 1'b0;
      updates      = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
      reg_writes++;
      case (index)
        CFG_USE_ROLL:   use_roll = value[0];
        CFG_INVERT:     invert = value[0];
        CFG_OFFSET:     mount_offset = int'($signed(value[15:0]));
        CFG_ANG_ALPHA:  angle_alpha = value;
        CFG_RATE_ALPHA: rate_alpha = value;
        default: ;
      endcase
    endfunction

    // One first-order step: acc moves toward target by alpha, floored.
    function longint smooth(longint acc, longint target, int unsigned alpha);
      longint a;
      a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
      return acc + ((a * (target - acc)) >>> 16);
    endfunction

    function void note_sample(logic signed [15:0] pitch, logic signed [15:0] roll,
                              logic [15:0] elapsed);
      longint axis_angle;
      longint target;
      longint rate_raw;
      longint ang_out;
      longint rate_out;
      bit clip;
      tilt_estimate_t est;
      if (elapsed <= 16'd1) begin
        dropped++;
        return;
      end
      axis_angle = use_roll ? longint'(roll) : longint'(pitch);
      if (invert) axis_angle = -axis_angle;
      axis_angle += mount_offset;
      target = axis_angle * 256;
      clip = 1'b0;
      if (!seeded) begin
        angle_acc  = target;
        prev_angle = target;
        rate_acc   = 0;
        seeded     = 1'b1;
      end else begin
        angle_acc = longint'(int'(smooth(angle_acc, target, angle_alpha)));
        // Angle change over elapsed time, scaled to 1/128 deg/s; truncates toward zero.
        rate_raw = ((angle_acc - prev_angle) * 15625) / (longint'(elapsed) * 4);
        if (rate_raw > RATE_MAX) begin
          rate_raw = RATE_MAX;
          clip = 1'b1;
        end else if (rate_raw < RATE_MIN) begin
          rate_raw = RATE_MIN;
          clip = 1'b1;
        end
        rate_acc   = smooth(rate_acc, rate_raw * 65536, rate_alpha);
        prev_angle = angle_acc;
      end
      updates++;
      ang_out = (angle_acc + 128) >>> 8;
      if (ang_out > ANGLE_TOP) ang_out = ANGLE_TOP;
      else if (ang_out < ANGLE_BOTTOM) ang_out = ANGLE_BOTTOM;
      rate_out = (rate_acc + 32768) >>> 16;
      if (rate_out > RATE_MAX) rate_out = RATE_MAX;
      else if (rate_out < RATE_MIN) rate_out = RATE_MIN;
      est.angle   = ang_out[15:0];
      est.rate    = rate_out[23:0];
      est.seq     = updates;
      est.clipped = clip;
      if (clip) clipped_seen++;
      pending.push_back(est);
    endfunction

    function void check_result(logic [71:0] data, logic user);
      tilt_estimate_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: angle %0d rate %0d seq %0d clip %0b",
                   $signed(data[15:0]), $signed(data[39:16]), data[71:40], user);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (data[15:0] !== want.angle || data[39:16] !== want.rate ||
          data[71:40] !== want.seq || user !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d (exp/got): angle %0d/%0d rate %0d/%0d seq %0d/%0d clip %0b/%0b",
                   checked, $signed(want.angle), $signed(data[15:0]),
                   $signed(want.rate), $signed(data[39:16]), want.seq, data[71:40],
                   want.clipped, user);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  tilt_scoreboard board = new();
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int pitch_track = 0;
  int roll_track = 0;

  tilt_angle_rate_estimator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check accepted words and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
      hold_cycles = $urandom_range(18, 1) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_sample(logic signed [15:0] pitch, logic signed [15:0] roll,
                             logic [15:0] elapsed);
    in_tdata  <= {elapsed, roll, pitch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_sample(pitch, roll, elapsed);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  // The valid stays high across back-to-back writes; configure lowers it.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(index, value);
  endtask

  // Registers change only with the block idle: every estimate back, then a pause
  // for the block to settle before the writes.
  task automatic configure(bit roll_sel, bit inv, int offset, int unsigned a_alpha,
                           int unsigned r_alpha);
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(CFG_USE_ROLL, CFG_DAT_W'(roll_sel));
    write_register(CFG_INVERT, CFG_DAT_W'(inv));
    write_register(CFG_OFFSET, offset[CFG_DAT_W-1:0]);
    write_register(CFG_ANG_ALPHA, a_alpha[CFG_DAT_W-1:0]);
    write_register(CFG_RATE_ALPHA, r_alpha[CFG_DAT_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_alpha();
    case ($urandom_range(7))
      0: return 0;
      1: return ALPHA_ONE;
      2: return $urandom_range(131071, 65537);
      3: return $urandom_range(255, 1);
      default: return $urandom_range(65535, 1);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(4))
      0: return ANGLE_SPAN;
      1: return -ANGLE_SPAN;
      2: return 0;
      default: return int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
    endcase
  endfunction

  function automatic int full_angle();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? ANGLE_SPAN : -ANGLE_SPAN;
    return int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
  endfunction

  function automatic int drift(int angle);
    int step;
    step = int'($urandom_range(600)) - 300;
    angle += step;
    if (angle > ANGLE_SPAN) angle = ANGLE_SPAN;
    else if (angle < -ANGLE_SPAN) angle = -ANGLE_SPAN;
    return angle;
  endfunction

  // Mostly smooth motion with occasional jumps; elapsed times from very short
  // (where the rate clips) to the full field, plus a few skipped words.
  task automatic random_updates(int kept_target);
    int kept;
    int pick;
    logic [15:0] elapsed;
    kept = 0;
    while (kept < kept_target) begin
      pick = $urandom_range(99);
      if (pick < 5) elapsed = 16'($urandom_range(1));
      else if (pick < 35) elapsed = 16'($urandom_range(40, 2));
      else if (pick < 85) elapsed = 16'($urandom_range(20000, 41));
      else elapsed = 16'($urandom_range(65535, 20001));
      if ($urandom_range(99) < 10) begin
        pitch_track = full_angle();
        roll_track  = full_angle();
      end else begin
        pitch_track = drift(pitch_track);
        roll_track  = drift(roll_track);
      end
      send_sample(16'(pitch_track), 16'(roll_track), elapsed);
      if (elapsed > 16'd1) kept++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: roll axis, no inversion, no offset, both alphas a quarter.
    // Short elapsed times before the first sample must not seed the filters.
    send_sample(16'sd0, 16'sd0, 16'd0);
    send_sample(16'sd100, 16'sd200, 16'd1);
    send_sample(-16'sd23040, 16'sd23040, 16'd2);
    send_sample(16'sd23040, -16'sd23040, 16'd2);
    send_sample(16'sd0, 16'sd0, 16'd65535);
    send_sample(-16'sd1, -16'sd1, 16'd0);
    send_sample(16'sd5, 16'sd300, 16'd1);
    send_sample(16'sd1000, 16'sd1000, 16'd3);

    // Pitch, inverted, offset at its top: the angle saturates high.
    configure(1'b0, 1'b1, ANGLE_SPAN, ALPHA_ONE, ALPHA_ONE);
    send_sample(-16'sd23040, 16'sd0, 16'd3);
    send_sample(16'sd23040, 16'sd12345, 16'd65535);
    send_sample(-16'sd1, 16'sd0, 16'd2);

    // Offset at its bottom saturates the angle low; the angle alpha is above one.
    configure(1'b1, 1'b0, -ANGLE_SPAN, 131071, 0);
    send_sample(16'sd0, -16'sd23040, 16'd2);
    send_sample(16'sd0, 16'sd23040, 16'd2);
    send_sample(16'sd0, 16'sd0, 16'd40000);

    // A frozen angle with the rate alpha just above one.
    configure(1'b0, 1'b1, 0, 0, 65537);
    send_sample(16'sd23040, -16'sd23040, 16'd2);
    send_sample(-16'sd23040, 16'sd23040, 16'd65535);
    send_sample(16'sd1, 16'sd2, 16'd2);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure($urandom_range(1), $urandom_range(1), pick_offset(), pick_alpha(),
                pick_alpha());
      if (ph == RANDOM_PHASES - 1) begin
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
      end else begin
        sender_idle_pct = $urandom_range(2) * 20;
        sink_stall_pct  = $urandom_range(2) * 8;
      end
      random_updates(PHASE_UPDATES);
    end

    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d estimates (%0d with a clipped rate); %0d short-interval words dropped.",
             board.checked, board.clipped_seen, board.dropped);
    $display("%0d register writes over %0d settings; %0d mismatches.",
             board.reg_writes, RANDOM_PHASES + 3, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
